// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the codec rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/b64sc_pkg.sv =====
// types, constants and character mapping functions for the base64 codec
// no dependencies; used by b64sc_group_unit and base64_stream_codec_unit
package b64sc_pkg;

   localparam int unsigned BURST_DEPTH = 4;
   localparam int unsigned COUNT_W     = 3;

   localparam logic [7:0] PAD_CHAR   = 8'h3D;
   localparam logic [7:0] PLUS_CHAR  = 8'h2B;
   localparam logic [7:0] SLASH_CHAR = 8'h2F;

   // slot of the word that closes a group
   localparam logic [1:0] ENC_LAST_POS = 2'd2;
   localparam logic [1:0] DEC_LAST_POS = 2'd3;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       length_error;
   } word_type;

   typedef struct packed {
      logic                           emit;
      logic [COUNT_W-1:0]             count;
      word_type [BURST_DEPTH-1:0]     words;
   } burst_type;

   // sextet to alphabet character
   function automatic logic [7:0] enc_char(input logic [5:0] sextet);
      logic [7:0] s8;
      logic [7:0] c;
      s8 = {2'b00, sextet};
      if (sextet inside {[6'd0:6'd25]}) begin
         c = 8'h41 + s8;
      end else if (sextet inside {[6'd26:6'd51]}) begin
         c = 8'h47 + s8;
      end else if (sextet inside {[6'd52:6'd61]}) begin
         c = s8 - 8'd4;
      end else if (sextet == 6'd62) begin
         c = PLUS_CHAR;
      end else begin
         c = SLASH_CHAR;
      end
      return c;
   endfunction

   // alphabet character to sextet, anything else to zero
   function automatic logic [5:0] dec_char(input logic [7:0] c);
      logic [7:0] v;
      if (c inside {[8'h41:8'h5A]}) begin
         v = c - 8'h41;
      end else if (c inside {[8'h61:8'h7A]}) begin
         v = c - 8'h47;
      end else if (c inside {[8'h30:8'h39]}) begin
         v = c + 8'd4;
      end else if (c == PLUS_CHAR) begin
         v = 8'd62;
      end else if (c == SLASH_CHAR) begin
         v = 8'd63;
      end else begin
         v = 8'd0;
      end
      return v[5:0];
   endfunction

endpackage

// ===== rtl/core/base64_stream_codec_unit.sv =====
// a word that completes a group shows its first result word in the next cycle
// throughput, while the receiver does not stall: one result word per cycle from a four-entry
//   burst register; encode is bound by the output, decode takes one character per cycle
// reset: synchronous, active high; encode mode, empty group, no pending results
// top level: burst buffer and handshakes; uses b64sc_pkg, b64sc_group_unit,
// assert_macros.svh
`include "assert_macros.svh"

module base64_stream_codec_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_wdata,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   output logic       rsp_length_error
);
   import b64sc_pkg::*;

   burst_type                  burst;
   logic                       take;
   logic                       drain;
   logic                       free;
   logic                       load;
   logic [COUNT_W-1:0]         count_ff;
   logic [COUNT_W-1:0]         count_in;
   word_type [BURST_DEPTH-1:0] words_ff;
   word_type [BURST_DEPTH-1:0] words_in;

   b64sc_group_unit u_group (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .take      (take),
      .in_byte   (req_in_byte),
      .in_last   (req_in_last),
      .burst     (burst)
   );

   // handshakes: a word that emits waits until the burst buffer frees up
   assign rsp_valid = (count_ff != '0);
   assign drain     = rsp_valid && !rsp_stall;
   assign free      = (count_ff == '0) || (drain && (count_ff == COUNT_W'(1)));
   assign req_stall = burst.emit && !free;
   assign take      = req_valid && !req_stall;
   assign load      = take && burst.emit;

   // burst buffer: load a whole group, shift one word out per accepted result
   always_comb begin
      count_in = count_ff;
      words_in = words_ff;
      if (load) begin
         count_in = burst.count;
         words_in = burst.words;
      end else if (drain) begin
         count_in = count_ff - COUNT_W'(1);
         for (int i = 0; i < BURST_DEPTH - 1; i++) begin
            words_in[i] = words_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      words_ff <= words_in;
   end

   assign rsp_out_byte     = words_ff[0].data;
   assign rsp_out_last     = words_ff[0].last;
   assign rsp_length_error = words_ff[0].length_error;

   // checks
   `ASSERT_IMPLY(a_count_range, clock, reset, 1'b1, count_ff <= COUNT_W'(BURST_DEPTH))
   `ASSERT_IMPLY(a_load_when_free, clock, reset, load, free)
   `ASSERT_IMPLY(a_error_word, clock, reset, rsp_valid && rsp_length_error, rsp_out_last && (rsp_out_byte == 8'd0))
   `ASSERT_NEXT(a_drain_continues, clock, reset, drain && (count_ff > COUNT_W'(1)), rsp_valid)

endmodule

// ===== rtl/core/b64sc_group_unit.sv =====
// group assembly for the base64 codec: direction register, partial group
// state and formation of the result words of a completed group; uses b64sc_pkg
module b64sc_group_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic                 csr_wdata,
   input  logic                 take,
   input  logic [7:0]           in_byte,
   input  logic                 in_last,
   output b64sc_pkg::burst_type burst
);
   import b64sc_pkg::*;

   logic        mode_ff;
   logic [23:0] group_ff;
   logic [1:0]  fill_ff;
   logic        third_pad_ff;

   logic        mode_in;
   logic [23:0] group_in;
   logic [1:0]  fill_in;
   logic        third_pad_in;

   logic [1:0]  enc_pos;
   logic [23:0] enc_base;
   logic [23:0] enc_shift;
   logic [23:0] enc_group;
   logic [5:0]  sextet;
   logic [23:0] dec_shift;
   logic [23:0] dec_group;
   logic        is_pad;
   logic [1:0]  drop;
   logic [1:0]  nbytes;

   // encode: place the byte in its slot of the group
   always_comb begin
      enc_pos  = (fill_ff == DEC_LAST_POS) ? 2'd0 : fill_ff;
      enc_base = (fill_ff == DEC_LAST_POS) ? 24'd0 : group_ff;
      case (enc_pos)
         2'd0:    enc_shift = {in_byte, 16'd0};
         2'd1:    enc_shift = {8'd0, in_byte, 8'd0};
         default: enc_shift = {16'd0, in_byte};
      endcase
      enc_group = enc_base | enc_shift;
   end

   // decode: place the sextet and work out trailing pad drops
   always_comb begin
      sextet = dec_char(in_byte);
      case (fill_ff)
         2'd0:    dec_shift = {sextet, 18'd0};
         2'd1:    dec_shift = {6'd0, sextet, 12'd0};
         2'd2:    dec_shift = {12'd0, sextet, 6'd0};
         default: dec_shift = {18'd0, sextet};
      endcase
      dec_group = group_ff | dec_shift;
      is_pad    = (in_byte == PAD_CHAR);
      drop      = in_last ? ({1'b0, is_pad} + {1'b0, third_pad_ff}) : 2'd0;
      nbytes    = 2'd3 - drop;
   end

   // result words for the current word
   always_comb begin
      burst = '0;
      if (!mode_ff) begin
         burst.emit           = (enc_pos == ENC_LAST_POS) || in_last;
         burst.count          = 3'd4;
         burst.words[0].data  = enc_char(enc_group[23:18]);
         burst.words[1].data  = enc_char(enc_group[17:12]);
         burst.words[2].data  = (enc_pos != 2'd0) ? enc_char(enc_group[11:6]) : PAD_CHAR;
         burst.words[3].data  = (enc_pos == ENC_LAST_POS) ? enc_char(enc_group[5:0])
                                                          : PAD_CHAR;
         burst.words[3].last  = in_last;
      end else if (fill_ff == DEC_LAST_POS) begin
         burst.emit           = 1'b1;
         burst.count          = {1'b0, nbytes};
         burst.words[0].data  = dec_group[23:16];
         burst.words[1].data  = dec_group[15:8];
         burst.words[2].data  = dec_group[7:0];
         burst.words[0].last  = in_last && (nbytes == 2'd1);
         burst.words[1].last  = in_last && (nbytes == 2'd2);
         burst.words[2].last  = in_last && (nbytes == 2'd3);
      end else begin
         // short final group: single error word
         burst.emit                  = in_last;
         burst.count                 = 3'd1;
         burst.words[0].last         = 1'b1;
         burst.words[0].length_error = 1'b1;
      end
   end

   // next group state
   always_comb begin
      mode_in      = mode_ff;
      group_in     = group_ff;
      fill_in      = fill_ff;
      third_pad_in = third_pad_ff;
      if (csr_we) begin
         mode_in      = csr_wdata;
         group_in     = 24'd0;
         fill_in      = 2'd0;
         third_pad_in = 1'b0;
      end else if (take) begin
         if (burst.emit) begin
            group_in     = 24'd0;
            fill_in      = 2'd0;
            third_pad_in = 1'b0;
         end else if (!mode_ff) begin
            group_in = enc_group;
            fill_in  = enc_pos + 2'd1;
         end else begin
            group_in = dec_group;
            fill_in  = fill_ff + 2'd1;
            if (fill_ff == 2'd2) begin
               third_pad_in = is_pad;
            end
         end
      end
   end

   // group state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         group_ff     <= 24'd0;
         fill_ff      <= 2'd0;
         third_pad_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         group_ff     <= group_in;
         fill_ff      <= fill_in;
         third_pad_ff <= third_pad_in;
      end
   end

endmodule

// ===== bench/base64_stream_codec_unit_test.sv =====
`timescale 1ns / 1ps
// self-checking bench for base64_stream_codec_unit: a directed table, then random
// messages in both directions checked word by word; needs b64sc_pkg and the codec rtl

module base64_stream_codec_unit_test;
   import b64sc_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ITEMS = 300;
   localparam int QUIET_AFTER  = 250;

   // typed-in result words of one table row; n below zero means use the predictor
   typedef struct {
      int               n;
      word_type [3:0]   w;
   } pinned_words_type;

   typedef struct {
      bit               is_write;
      logic [7:0]       data;
      logic             last;
      int               pin_n;
      word_type [3:0]   pin;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we = 1'b0;
   logic       csr_wdata = 1'b0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_in_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;
   logic       rsp_length_error;

   // predictor state
   logic        mode_now = 1'b0;
   logic [23:0] group_acc = '0;
   logic [1:0]  group_fill = '0;
   logic        third_pad = 1'b0;

   word_type         expected_words[$];
   pinned_words_type pinned_q[$];
   stim_row_type     stim_rows[$];
   logic [7:0]       msg_bytes[$];

   int  error_count = 0;
   int  cycle_count = 0;
   int  gap_pct = 30;
   int  stall_pct = 30;
   int  stall_left = 0;
   bit  quiet = 1'b0;
   int  idle_levels[4] = '{0, 10, 30, 60};

   base64_stream_codec_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_in_last      (req_in_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_last     (rsp_out_last),
      .rsp_length_error (rsp_length_error)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // alphabet lookup, both ways
   function automatic logic [7:0] sextet_to_char(input logic [5:0] s);
      if (s < 6'd26) begin
         return 8'h41 + s;
      end else if (s < 6'd52) begin
         return 8'h61 + s - 8'd26;
      end else if (s < 6'd62) begin
         return 8'h30 + s - 8'd52;
      end else if (s == 6'd62) begin
         return PLUS_CHAR;
      end
      return SLASH_CHAR;
   endfunction

   function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) begin
         return 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         return 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         return 6'(c - 8'h30 + 8'd52);
      end else if (c == PLUS_CHAR) begin
         return 6'd62;
      end else if (c == SLASH_CHAR) begin
         return 6'd63;
      end
      return 6'd0;
   endfunction

   function automatic word_type wd(input logic [7:0] d, input logic l, input logic e);
      wd = '{data: d, last: l, length_error: e};
   endfunction

   task automatic clear_group();
      group_acc  = '0;
      group_fill = '0;
      third_pad  = 1'b0;
   endtask

   // result words caused by one accepted word
   task automatic codec_predict(input logic [7:0] b, input logic l,
                                output int n, output word_type [3:0] w);
      logic [1:0] pos;
      logic       pad;
      logic [7:0] c;
      int         nchar;
      int         nbytes;
      w   = '0;
      n   = 0;
      pos = group_fill;
      if (!mode_now) begin
         // encode: three bytes make four characters, short final group is padded
         group_acc = group_acc | ({16'h0, b} << (16 - 8 * pos));
         if (pos == ENC_LAST_POS || l) begin
            nchar = int'(pos) + 2;
            for (int k = 0; k < 4; k++) begin
               c = (k < nchar) ? sextet_to_char(group_acc[23 - 6 * k -: 6]) : PAD_CHAR;
               w[k] = wd(c, (k == 3) ? l : 1'b0, 1'b0);
            end
            n = 4;
            clear_group();
         end else begin
            group_fill = pos + 2'd1;
         end
      end else begin
         // decode: four characters make three bytes, trailing pads drop bytes
         pad = (b == PAD_CHAR);
         group_acc = group_acc | ({18'h0, char_to_sextet(b)} << (18 - 6 * pos));
         if (pos == 2'd2) begin
            third_pad = pad;
         end
         if (pos == DEC_LAST_POS) begin
            nbytes = 3;
            if (l) begin
               nbytes = nbytes - int'(pad) - int'(third_pad);
            end
            for (int k = 0; k < nbytes; k++) begin
               w[k] = wd(group_acc[23 - 8 * k -: 8], (k + 1 == nbytes) ? l : 1'b0, 1'b0);
            end
            n = nbytes;
            clear_group();
         end else if (l) begin
            w[0] = wd(8'h00, 1'b1, 1'b1);
            n = 1;
            clear_group();
         end else begin
            group_fill = pos + 2'd1;
         end
      end
   endtask

   task automatic report_mismatch(input string what);
      error_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // result check, register tracking and prediction at each edge
   always @(posedge clock) begin : monitor
      int               n;
      word_type [3:0]   w;
      word_type         got;
      word_type         want;
      pinned_words_type pw;
      if (reset) begin
         mode_now = 1'b0;
         clear_group();
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            got = wd(rsp_out_byte, rsp_out_last, rsp_length_error);
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("result word %h/%b/%b with nothing expected",
                  got.data, got.last, got.length_error));
            end else begin
               want = expected_words.pop_front();
               if (got !== want) begin
                  report_mismatch($sformatf(
                     "data %h want %h, last %b want %b, length_error %b want %b",
                     got.data, want.data, got.last, want.last,
                     got.length_error, want.length_error));
               end
            end
         end
         if (csr_we) begin
            mode_now = csr_wdata;
            clear_group();
         end
         if (req_valid && req_stall == 1'b0) begin
            codec_predict(req_in_byte, req_in_last, n, w);
            pw = pinned_q.pop_front();
            if (pw.n >= 0) begin
               n = pw.n;
               w = pw.w;
            end
            for (int k = 0; k < n; k++) begin
               expected_words.push_back(w[k]);
            end
         end
      end
   end

   // receiver stall bursts
   always @(posedge clock) begin
      if (reset || quiet) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(99) < stall_pct) begin
         stall_left = $urandom_range(1, 13) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("base64_stream_codec_unit_test NOT OK");
         $finish;
      end
   end

   // present one word and hold it until taken
   task automatic send_word(input logic [7:0] b, input logic l,
                            input int pin_n, input word_type [3:0] pin);
      pinned_words_type pw;
      if (!quiet && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      pw.n = pin_n;
      pw.w = pin;
      pinned_q.push_back(pw);
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= l;
      do @(posedge clock); while (req_stall);
   endtask

   // hold the sender until every expected word is out
   task automatic pause_until_drained(input int extra);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_mode(input logic v);
      pause_until_drained(DRAIN_CYCLES);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic add_row(input bit is_write, input logic [7:0] d, input logic l,
                          input int pin_n, input word_type w0, input word_type w1,
                          input word_type w2, input word_type w3);
      stim_row_type r;
      r.is_write = is_write;
      r.data     = d;
      r.last     = l;
      r.pin_n    = pin_n;
      r.pin[0]   = w0;
      r.pin[1]   = w1;
      r.pin[2]   = w2;
      r.pin[3]   = w3;
      stim_rows.push_back(r);
   endtask

   task automatic send_message(input bit drop_last);
      for (int i = 0; i < msg_bytes.size(); i++) begin
         send_word(msg_bytes[i], (i == msg_bytes.size() - 1) && !drop_last, -1, '0);
      end
   endtask

   // random alphabet character, with an occasional pad
   function automatic logic [7:0] rand_b64_char(input int pad_one_in);
      if ($urandom_range(pad_one_in - 1) == 0) begin
         return PAD_CHAR;
      end
      return sextet_to_char(6'($urandom_range(63)));
   endfunction

   task automatic run_random();
      int   sent;
      int   n_msg;
      int   kind;
      int   sz;
      logic new_mode;
      bit   drop_last;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         new_mode = 1'($urandom_range(1));
         if (sent >= QUIET_AFTER) begin
            quiet = 1'b1;
         end
         gap_pct   = quiet ? 0 : idle_levels[$urandom_range(3)];
         stall_pct = quiet ? 0 : idle_levels[$urandom_range(3)];
         write_mode(new_mode);
         n_msg = $urandom_range(2, 6);
         for (int m = 0; m < n_msg; m++) begin
            msg_bytes.delete();
            if (!new_mode) begin
               repeat ($urandom_range(1, 10)) msg_bytes.push_back(8'($urandom_range(255)));
            end else begin
               kind = $urandom_range(9);
               if (kind < 7) begin
                  // groups of four, final group with a random pad pattern
                  repeat (4 * $urandom_range(1, 3)) msg_bytes.push_back(rand_b64_char(20));
                  sz = msg_bytes.size();
                  case ($urandom_range(3))
                     1: begin
                        msg_bytes[sz - 1] = PAD_CHAR;
                     end
                     2: begin
                        msg_bytes[sz - 2] = PAD_CHAR;
                        msg_bytes[sz - 1] = PAD_CHAR;
                     end
                     3: begin
                        msg_bytes[sz - 2] = PAD_CHAR;
                        msg_bytes[sz - 1] = sextet_to_char(6'($urandom_range(63)));
                     end
                     default: begin
                     end
                  endcase
               end else if (kind == 7) begin
                  // length not a multiple of four
                  repeat (4 * $urandom_range(0, 2) + $urandom_range(1, 3)) begin
                     msg_bytes.push_back(rand_b64_char(6));
                  end
               end else begin
                  // arbitrary bytes
                  repeat ($urandom_range(1, 9)) msg_bytes.push_back(8'($urandom_range(255)));
               end
            end
            drop_last = (m == n_msg - 1) && ($urandom_range(7) == 0);
            send_message(drop_last);
            sent += msg_bytes.size();
            if ($urandom_range(5) == 0) begin
               pause_until_drained(0);
            end
         end
      end
   endtask

   initial begin
      // encode from reset: all-ones group, single zero byte, two-byte final, abandoned byte
      add_row(1'b0, 8'hFF, 1'b0, 0, '0, '0, '0, '0);
      add_row(1'b0, 8'hFF, 1'b0, 0, '0, '0, '0, '0);
      add_row(1'b0, 8'hFF, 1'b0, 4, wd(SLASH_CHAR, 1'b0, 1'b0), wd(SLASH_CHAR, 1'b0, 1'b0),
              wd(SLASH_CHAR, 1'b0, 1'b0), wd(SLASH_CHAR, 1'b0, 1'b0));
      add_row(1'b0, 8'h00, 1'b1, 4, wd(8'h41, 1'b0, 1'b0), wd(8'h41, 1'b0, 1'b0),
              wd(PAD_CHAR, 1'b0, 1'b0), wd(PAD_CHAR, 1'b1, 1'b0));
      add_row(1'b0, 8'h4D, 1'b0, -1, '0, '0, '0, '0);
      add_row(1'b0, 8'h61, 1'b1, -1, '0, '0, '0, '0);
      add_row(1'b0, 8'h5A, 1'b0, 0, '0, '0, '0, '0);
      // direction change drops the partial group
      add_row(1'b1, 8'h01, 1'b0, 0, '0, '0, '0, '0);
      // decode: single pad, double pad
      add_row(1'b0, 8'h54, 1'b0, -1, '0, '0, '0, '0);
      add_row(1'b0, 8'h57, 1'b0, -1, '0, '0, '0, '0);
      add_row(1'b0, 8'h45, 1'b0, -1, '0, '0, '0, '0);
      add_row(1'b0, PAD_CHAR, 1'b1, -1, '0, '0, '0, '0);
      add_row(1'b0, 8'h51, 1'b0, -1, '0, '0, '0, '0);
      add_row(1'b0, 8'h51, 1'b0, -1, '0, '0, '0, '0);
      add_row(1'b0, PAD_CHAR, 1'b0, -1, '0, '0, '0, '0);
      add_row(1'b0, PAD_CHAR, 1'b1, -1, '0, '0, '0, '0);
      // out-of-alphabet extremes with a lone pad in the third slot
      add_row(1'b0, 8'hFF, 1'b0, 0, '0, '0, '0, '0);
      add_row(1'b0, 8'h00, 1'b0, 0, '0, '0, '0, '0);
      add_row(1'b0, PAD_CHAR, 1'b0, 0, '0, '0, '0, '0);
      add_row(1'b0, 8'h7E, 1'b1, 2, wd(8'h00, 1'b0, 1'b0), wd(8'h00, 1'b1, 1'b0), '0, '0);
      // pads inside a message, then a short final group
      add_row(1'b0, PLUS_CHAR, 1'b0, -1, '0, '0, '0, '0);
      add_row(1'b0, PAD_CHAR, 1'b0, -1, '0, '0, '0, '0);
      add_row(1'b0, SLASH_CHAR, 1'b0, -1, '0, '0, '0, '0);
      add_row(1'b0, PAD_CHAR, 1'b0, -1, '0, '0, '0, '0);
      add_row(1'b0, SLASH_CHAR, 1'b1, 1, wd(8'h00, 1'b1, 1'b1), '0, '0, '0);
      add_row(1'b1, 8'h00, 1'b0, 0, '0, '0, '0, '0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         if (stim_rows[i].is_write) begin
            write_mode(stim_rows[i].data[0]);
         end else begin
            send_word(stim_rows[i].data, stim_rows[i].last, stim_rows[i].pin_n,
                      stim_rows[i].pin);
         end
      end

      run_random();

      pause_until_drained(DRAIN_CYCLES + 4);
      if (error_count == 0) begin
         $display("base64_stream_codec_unit_test OK");
      end else begin
         $display("base64_stream_codec_unit_test NOT OK");
      end
      $finish;
   end

endmodule

// ===== base64_stream_codec_unit.f =====
+incdir+rtl/core
rtl/core/b64sc_pkg.sv
rtl/core/b64sc_group_unit.sv
rtl/core/base64_stream_codec_unit.sv
bench/base64_stream_codec_unit_test.sv
